@@ rtl/uart_rb_pkg.sv @@
// Shared types, register offsets and constants for the UART register block.
package uart_rb_pkg;

  // Default receive ring depth in slots; the ring holds one byte less
  localparam int RX_DEPTH_DEF = 16;

  localparam int ADDR_W = 12;
  localparam int DATA_W = 32;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 11;

  // Item command codes
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Register byte offsets
  localparam logic [ADDR_W-1:0] OFS_DATA  = 12'h000;
  localparam logic [ADDR_W-1:0] OFS_FLAG  = 12'h018;
  localparam logic [ADDR_W-1:0] OFS_IBRD  = 12'h024;
  localparam logic [ADDR_W-1:0] OFS_FBRD  = 12'h028;
  localparam logic [ADDR_W-1:0] OFS_LCR   = 12'h02C;
  localparam logic [ADDR_W-1:0] OFS_CTRL  = 12'h030;
  localparam logic [ADDR_W-1:0] OFS_LEVEL = 12'h034;
  localparam logic [ADDR_W-1:0] OFS_MASK  = 12'h038;
  localparam logic [ADDR_W-1:0] OFS_RAW   = 12'h03C;
  localparam logic [ADDR_W-1:0] OFS_MIS   = 12'h040;
  localparam logic [ADDR_W-1:0] OFS_CLEAR = 12'h044;
  localparam logic [ADDR_W-1:0] ID_FIRST  = 12'hFE0;
  localparam logic [ADDR_W-1:0] ID_LAST   = 12'hFFC;

  // Flag and status bits
  localparam logic [BYTE_W-1:0] FLAG_RXFE  = 8'h10;
  localparam logic [BYTE_W-1:0] FLAG_TXFE  = 8'h80;
  localparam logic [STAT_W-1:0] RAW_RX_BIT = 11'h010;

  // Reset values
  localparam logic [15:0] CTRL_RST  = 16'h0301;
  localparam logic [5:0]  LEVEL_RST = 6'h12;

  // One result item
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              irq_level;
  } result_t;

  // Peripheral identification bytes, one per word
  function automatic logic [BYTE_W-1:0] id_byte(input logic [2:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      3'd0: b = 8'h11;
      3'd1: b = 8'h10;
      3'd2: b = 8'h14;
      3'd3: b = 8'h00;
      3'd4: b = 8'h0d;
      3'd5: b = 8'hf0;
      3'd6: b = 8'h05;
      3'd7: b = 8'hb1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/uart_rb_regs.sv @@
// Register file, receive ring and result stage of the UART register block.
module uart_rb_regs #(
  parameter int RX_DEPTH = uart_rb_pkg::RX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         acc,
  input  logic [1:0]                   cmd,
  input  logic [uart_rb_pkg::ADDR_W-1:0] offset,
  input  logic [uart_rb_pkg::DATA_W-1:0] write_data,
  input  logic [uart_rb_pkg::BYTE_W-1:0] rx_byte,
  input  logic                         s1_take,
  output logic                         s1_valid,
  output uart_rb_pkg::result_t         s1_res
);
  import uart_rb_pkg::*;

  localparam int PTR_W = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_DEPTH - 1);

  // Receive ring storage
  logic [BYTE_W-1:0] ring [RX_DEPTH];
  logic [BYTE_W-1:0] rd_q;

  logic [PTR_W-1:0] rd_ptr, wr_ptr, rd_inc, wr_inc;
  logic [15:0]       control, baud_int;
  logic [7:0]        line_ctrl;
  logic [5:0]        baud_frac, fifo_level;
  logic [STAT_W-1:0] irq_mask, raw_status, irq_mask_next, raw_status_next;

  logic is_read, is_write, is_rx, ring_empty, ring_full, pop, push;
  logic [DATA_W-1:0] word;

  // Result stage
  logic              s1_pop;
  logic [DATA_W-1:0] s1_word;
  logic              s1_tx_valid;
  logic [BYTE_W-1:0] s1_tx_byte;
  logic              s1_irq;

  // Decode the accepted item
  always_comb begin
    is_read  = acc && (cmd == CMD_READ);
    is_write = acc && (cmd == CMD_WRITE);
    is_rx    = acc && (cmd == CMD_RX);
    rd_inc   = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
    wr_inc   = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
    ring_empty = (rd_ptr == wr_ptr);
    ring_full  = (wr_inc == rd_ptr);
    pop  = is_read && (offset == OFS_DATA) && !ring_empty;
    push = is_rx && !ring_full;
  end

  // Select the read word for every register but the popped data
  always_comb begin
    word = '0;
    if (is_read) begin
      unique case (offset)
        OFS_FLAG:  word = DATA_W'(ring_empty ? (FLAG_TXFE | FLAG_RXFE) : FLAG_TXFE);
        OFS_CTRL:  word = DATA_W'(control);
        OFS_LCR:   word = DATA_W'(line_ctrl);
        OFS_IBRD:  word = DATA_W'(baud_int);
        OFS_FBRD:  word = DATA_W'(baud_frac);
        OFS_MASK:  word = DATA_W'(irq_mask);
        OFS_RAW:   word = DATA_W'(raw_status);
        OFS_MIS:   word = DATA_W'(raw_status & irq_mask);
        OFS_LEVEL: word = DATA_W'(fifo_level);
        default: begin
          if (offset >= ID_FIRST && offset <= ID_LAST) begin
            word = DATA_W'(id_byte(offset[4:2]));
          end
        end
      endcase
    end
  end

  // Status and mask after this item
  always_comb begin
    irq_mask_next   = irq_mask;
    raw_status_next = raw_status;
    if (is_write && offset == OFS_MASK) begin
      irq_mask_next = write_data[STAT_W-1:0];
    end
    if (is_write && offset == OFS_CLEAR) begin
      raw_status_next = raw_status & ~write_data[STAT_W-1:0];
    end
    if (push) begin
      raw_status_next = raw_status | RAW_RX_BIT;
    end
  end

  // Ring write and registered ring read
  always_ff @(posedge clk) begin
    if (push) begin
      ring[wr_ptr] <= rx_byte;
    end
    if (acc) begin
      rd_q <= ring[rd_ptr];
    end
  end

  // Update registers and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      control    <= CTRL_RST;
      line_ctrl  <= '0;
      baud_int   <= '0;
      baud_frac  <= '0;
      fifo_level <= LEVEL_RST;
      irq_mask   <= '0;
      raw_status <= '0;
    end else begin
      irq_mask   <= irq_mask_next;
      raw_status <= raw_status_next;
      if (pop) begin
        rd_ptr <= rd_inc;
      end
      if (push) begin
        wr_ptr <= wr_inc;
      end
      if (is_write) begin
        unique case (offset)
          OFS_CTRL:  control    <= write_data[15:0];
          OFS_LCR:   line_ctrl  <= write_data[7:0];
          OFS_IBRD:  baud_int   <= write_data[15:0];
          OFS_FBRD:  baud_frac  <= write_data[5:0];
          OFS_LEVEL: fifo_level <= write_data[5:0];
          default: ;
        endcase
      end
    end
  end

  // Advance the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pop      <= pop;
      s1_word     <= word;
      s1_tx_valid <= is_write && (offset == OFS_DATA);
      s1_tx_byte  <= (is_write && offset == OFS_DATA) ? write_data[BYTE_W-1:0] : '0;
      s1_irq      <= |(raw_status_next & irq_mask_next);
    end
  end

  // Merge popped byte into the result
  always_comb begin
    s1_res.read_data = s1_pop ? DATA_W'(rd_q) : s1_word;
    s1_res.tx_valid  = s1_tx_valid;
    s1_res.tx_byte   = s1_tx_byte;
    s1_res.irq_level = s1_irq;
  end

endmodule

@@ rtl/uart_rb_obuf.sv @@
// Two-entry output buffer that decouples the result stage from the receiver stall.
module uart_rb_obuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  uart_rb_pkg::result_t push_res,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output uart_rb_pkg::result_t out_res
);
  import uart_rb_pkg::*;

  logic    skid_valid;
  result_t skid;
  logic    pop;

  assign pop   = out_valid && !out_stall;
  assign ready = !skid_valid;

  // Hold control state of the two entries
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Move payloads
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid <= push_res;
      end else begin
        out_res <= push_res;
      end
    end
  end

endmodule

@@ rtl/uart_register_block_rx_fifo.sv @@
// UART register block with a receive ring: top level.
//
// Input channel (in_valid / in_stall) carries one item per cycle while in_stall
// is low: a bus read, a bus write or a received byte (cmd), with offset,
// write_data and rx_byte. Output channel (out_valid / out_stall) returns
// exactly one result item per input item, in order: read_data, tx_valid,
// tx_byte and irq_level. An accepted item passes the result stage (register
// decode and ring read register), then the output register, to out_valid.
// The block takes one item per cycle while in_stall is low; the registers,
// ring pointers, ring write and ring read register update on acceptance.
// The receive ring holds RX_DEPTH-1 bytes; a byte arriving at a full ring is
// dropped. A data read of an empty ring returns zero.
// Reset clears the pointers and registers to their defaults; ring contents
// are not cleared and are never read before written.
// When the receiver stalls, a two-entry output buffer absorbs results;
// in_stall rises only when both buffer entries and the result stage are full.
module uart_register_block_rx_fifo #(
  parameter int RX_DEPTH = uart_rb_pkg::RX_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic [uart_rb_pkg::ADDR_W-1:0] offset,
  input  logic [uart_rb_pkg::DATA_W-1:0] write_data,
  input  logic [uart_rb_pkg::BYTE_W-1:0] rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [uart_rb_pkg::DATA_W-1:0] read_data,
  output logic                           tx_valid,
  output logic [uart_rb_pkg::BYTE_W-1:0] tx_byte,
  output logic                           irq_level
);
  import uart_rb_pkg::*;

  logic    acc, s1_valid, s1_take, obuf_ready;
  result_t s1_res, out_res;

  // Accept an item when the result stage is empty or can drain
  assign in_stall = s1_valid && !obuf_ready;
  assign acc      = in_valid && !in_stall;
  assign s1_take  = s1_valid && obuf_ready;

  uart_rb_regs #(
    .RX_DEPTH(RX_DEPTH)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .cmd       (cmd),
    .offset    (offset),
    .write_data(write_data),
    .rx_byte   (rx_byte),
    .s1_take   (s1_take),
    .s1_valid  (s1_valid),
    .s1_res    (s1_res)
  );

  uart_rb_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_take),
    .push_res (s1_res),
    .ready    (obuf_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  // Drive result ports
  assign read_data = out_res.read_data;
  assign tx_valid  = out_res.tx_valid;
  assign tx_byte   = out_res.tx_byte;
  assign irq_level = out_res.irq_level;

endmodule
